[design/brd_pkg.sv]
`default_nettype none

package brd_pkg;

  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned LimitW       = 16;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned LenW         = 7;
  localparam logic [LimitW-1:0] LimitRst = 16'hFFFF;

  // controller -> datapath
  typedef struct packed {
    logic clear;         // end of image: counters back to reset
    logic load_lit_len;  // literal header taken
    logic load_pend;     // repeat count header taken
    logic emit_lit;      // pass one literal byte to the output
    logic start_rep;     // value byte taken, repeat run begins
    logic emit_rep;      // one repeat word to the output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic under_limit;
    logic hdr_flag;
    logic len_zero;
    logic lit_one;
    logic rep_empty;
    logic rep_final;
  } status_t;

endpackage

`default_nettype wire

[design/byte_rle_decoder_top.sv]
// A literal word is registered in the output register when its byte is taken; a repeat's
// value byte goes to a value register first and its first word follows once output is free.
// Header and literal bytes are taken one per cycle while the output register is free.
// A repeat stalls the input while the controller drains it through the output register,
// two bytes a word (one in the last word of an odd run).
// Reset (rst_ni low, asynchronous) clears the decode state and output count and
// sets the output limit to 65535.
`default_nettype none

module byte_rle_decoder_top #(
  parameter int unsigned COUNT_BITS = brd_pkg::CountBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [brd_pkg::LimitW-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [brd_pkg::ByteW-1:0]   data_byte_i,
  input  wire logic                        last_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [brd_pkg::ByteW-1:0]        out_byte_a_o,
  output logic [brd_pkg::ByteW-1:0]        out_byte_b_o,
  output logic                             pair_valid_o,
  output logic                             run_last_o,
  output logic                             limit_reached_o
);

  brd_pkg::cmd_t    cmd;
  brd_pkg::status_t status;

  brd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  brd_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .data_byte_i     (data_byte_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_byte_a_o    (out_byte_a_o),
    .out_byte_b_o    (out_byte_b_o),
    .pair_valid_o    (pair_valid_o),
    .run_last_o      (run_last_o),
    .limit_reached_o (limit_reached_o)
  );

endmodule

`default_nettype wire

[design/brd_datapath.sv]
`default_nettype none

module brd_datapath #(
  parameter int unsigned COUNT_BITS = brd_pkg::CountBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [brd_pkg::LimitW-1:0]   cfg_wdata_i,
  input  wire logic [brd_pkg::ByteW-1:0]    data_byte_i,
  input  wire logic                         out_ready_i,
  input  wire brd_pkg::cmd_t                cmd_i,
  output brd_pkg::status_t                  status_o,
  output logic                              out_valid_o,
  output logic [brd_pkg::ByteW-1:0]         out_byte_a_o,
  output logic [brd_pkg::ByteW-1:0]         out_byte_b_o,
  output logic                              pair_valid_o,
  output logic                              run_last_o,
  output logic                              limit_reached_o
);

  localparam int unsigned CmpW =
    (COUNT_BITS > brd_pkg::LimitW) ? COUNT_BITS : brd_pkg::LimitW;
  localparam int unsigned LenW = brd_pkg::LenW;

  logic [brd_pkg::LimitW-1:0] limit_q;
  logic [COUNT_BITS-1:0]      cnt_q;
  logic [LenW-1:0]            lit_left_q;
  logic [LenW-1:0]            pend_q;
  logic [LenW-1:0]            rem_q;
  logic [brd_pkg::ByteW-1:0]  val_q;

  logic                       out_valid_q;
  logic [brd_pkg::ByteW-1:0]  out_a_q;
  logic [brd_pkg::ByteW-1:0]  out_b_q;
  logic                       pair_q;
  logic                       run_last_q;
  logic                       limit_hit_q;

  logic [CmpW-1:0] cnt_w;
  logic [CmpW-1:0] cnt_max_w;
  logic [CmpW-1:0] lim_raw_w;
  logic [CmpW-1:0] lim_w;
  logic [CmpW-1:0] room_w;
  logic [CmpW-1:0] step_w;
  logic [CmpW-1:0] cnt_next_w;
  logic [LenW-1:0] rep_k;
  logic            rep_pair;
  logic [LenW-1:0] rem_next;
  logic            out_free;

  always_comb begin
    cnt_w      = CmpW'(cnt_q);
    cnt_max_w  = CmpW'({COUNT_BITS{1'b1}});
    lim_raw_w  = CmpW'(limit_q);
    lim_w      = (lim_raw_w > cnt_max_w) ? cnt_max_w : lim_raw_w;
    room_w     = lim_w - cnt_w;
    rep_k      = (CmpW'(pend_q) > room_w) ? room_w[LenW-1:0] : pend_q;
    rep_pair   = (rem_q[LenW-1:1] != '0);
    rem_next   = rem_q - (rep_pair ? LenW'(2) : LenW'(1));
    step_w     = (cmd_i.emit_rep && rep_pair) ? CmpW'(2) : CmpW'(1);
    cnt_next_w = cnt_w + step_w;
    out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    status_o.out_free    = out_free;
    status_o.under_limit = (cnt_w < lim_w);
    status_o.hdr_flag    = data_byte_i[brd_pkg::ByteW-1];
    status_o.len_zero    = (data_byte_i[LenW-1:0] == '0);
    status_o.lit_one     = (lit_left_q == LenW'(1));
    status_o.rep_empty   = (rep_k == '0);
    status_o.rep_final   = (rem_next == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= brd_pkg::LimitRst;
      cnt_q       <= '0;
      lit_left_q  <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        cnt_q      <= '0;
        lit_left_q <= '0;
        pend_q     <= '0;
      end else begin
        if (cmd_i.emit_lit || cmd_i.emit_rep) begin
          cnt_q <= cnt_next_w[COUNT_BITS-1:0];
        end
        if (cmd_i.load_lit_len) begin
          lit_left_q <= data_byte_i[LenW-1:0];
        end else if (cmd_i.emit_lit) begin
          lit_left_q <= lit_left_q - LenW'(1);
        end
        if (cmd_i.load_pend) begin
          pend_q <= data_byte_i[LenW-1:0];
        end else if (cmd_i.start_rep) begin
          pend_q <= '0;
        end
      end
      if (cmd_i.emit_lit || cmd_i.emit_rep) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_rep) begin
      val_q <= data_byte_i;
      rem_q <= rep_k;
    end else if (cmd_i.emit_rep) begin
      rem_q <= rem_next;
    end
    if (cmd_i.emit_lit) begin
      out_a_q     <= data_byte_i;
      out_b_q     <= '0;
      pair_q      <= 1'b0;
      run_last_q  <= 1'b1;
      limit_hit_q <= (cnt_next_w >= lim_w);
    end else if (cmd_i.emit_rep) begin
      out_a_q     <= val_q;
      out_b_q     <= rep_pair ? val_q : '0;
      pair_q      <= rep_pair;
      run_last_q  <= (rem_next == '0);
      limit_hit_q <= (cnt_next_w >= lim_w);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_a_o    = out_a_q;
  assign out_byte_b_o    = out_b_q;
  assign pair_valid_o    = pair_q;
  assign run_last_o      = run_last_q;
  assign limit_reached_o = limit_hit_q;

endmodule

`default_nettype wire

[design/brd_ctrl.sv]
`default_nettype none

module brd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              last_byte_i,
  output logic                   in_ready_o,
  input  wire brd_pkg::status_t  status_i,
  output brd_pkg::cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_VALUE,
    PH_REPEAT
  } phase_e;

  phase_e phase_q, phase_d;
  logic   last_pend_q, last_pend_d;
  logic   acc;

  assign in_ready_o = status_i.out_free && (phase_q != PH_REPEAT);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o       = '0;
    phase_d     = phase_q;
    last_pend_d = last_pend_q;
    unique case (phase_q)
      PH_LITERAL: begin
        if (acc) begin
          if (status_i.under_limit) begin
            cmd_o.emit_lit = 1'b1;
            if (status_i.lit_one) begin
              phase_d = PH_HEADER;
            end
          end
          if (last_byte_i) begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_HEADER;
          end
        end
      end
      PH_VALUE: begin
        if (acc) begin
          if (status_i.under_limit && !status_i.rep_empty) begin
            // run drains first; an end of image is honoured after it
            cmd_o.start_rep = 1'b1;
            phase_d         = PH_REPEAT;
            last_pend_d     = last_byte_i;
          end else begin
            if (status_i.under_limit) begin
              phase_d = PH_HEADER;
            end
            if (last_byte_i) begin
              cmd_o.clear = 1'b1;
              phase_d     = PH_HEADER;
            end
          end
        end
      end
      PH_REPEAT: begin
        if (status_i.out_free) begin
          cmd_o.emit_rep = 1'b1;
          if (status_i.rep_final) begin
            phase_d     = PH_HEADER;
            cmd_o.clear = last_pend_q;
            last_pend_d = 1'b0;
          end
        end
      end
      default: begin
        if (acc) begin
          if (status_i.under_limit) begin
            if (status_i.hdr_flag) begin
              cmd_o.load_lit_len = 1'b1;
              phase_d = status_i.len_zero ? PH_HEADER : PH_LITERAL;
            end else begin
              cmd_o.load_pend = 1'b1;
              phase_d         = PH_VALUE;
            end
          end
          if (last_byte_i) begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_HEADER;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      last_pend_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      last_pend_q <= last_pend_d;
    end
  end

endmodule

`default_nettype wire

[design/brd_checker.sv]
`default_nettype none

module brd_assertions (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_a_o,
  input wire logic [7:0] out_byte_b_o,
  input wire logic       pair_valid_o,
  input wire logic       run_last_o,
  input wire logic       limit_reached_o
);

  // a single byte only ever closes a run
  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |-> run_last_o)
    else $error("single-byte word not marked run_last");

  // the limit can only be hit on the final word of a run
  a_limit_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && limit_reached_o |-> run_last_o)
    else $error("limit_reached before end of run");

  a_b_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |-> out_byte_b_o == 8'h00)
    else $error("second byte not zero on single word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_a_o)
      && $stable(out_byte_b_o) && $stable(pair_valid_o) && $stable(run_last_o))
    else $error("stalled output word changed");

  // a stalled output word blocks the input
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output word stalled");

endmodule

bind byte_rle_decoder_top brd_assertions u_brd_assertions (.*);

`default_nettype wire

[test/brd_checker.sv]
`default_nettype none

module brd_checker #(
  parameter int unsigned COUNT_BITS = brd_pkg::CountBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [brd_pkg::LimitW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic [brd_pkg::ByteW-1:0]  data_byte_i,
  input  wire logic                       last_byte_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [brd_pkg::ByteW-1:0]  out_byte_a_i,
  input  wire logic [brd_pkg::ByteW-1:0]  out_byte_b_i,
  input  wire logic                       pair_valid_i,
  input  wire logic                       run_last_i,
  input  wire logic                       limit_reached_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef enum logic [1:0] {
    DecHeader  = 2'd0,
    DecLiteral = 2'd1,
    DecValue   = 2'd2
  } dec_phase_e;

  typedef struct {
    logic [brd_pkg::ByteW-1:0] byte_a;
    logic [brd_pkg::ByteW-1:0] byte_b;
    logic                      pair;
    logic                      run_last;
    logic                      at_limit;
  } word_t;

  localparam longint unsigned CountMax = (64'd1 << COUNT_BITS) - 64'd1;

  string field_name [5] = '{"out_byte_a", "out_byte_b", "pair_valid", "run_last",
                            "limit_reached"};

  logic [brd_pkg::LimitW-1:0] limit_q;
  dec_phase_e                 phase_q;
  logic [brd_pkg::LenW-1:0]   lit_left_q;
  logic [brd_pkg::LenW-1:0]   rep_count_q;
  longint unsigned            out_cnt_q;
  word_t                      decoded_q [$];
  int                         fails;

  function automatic word_t pack_word(logic [brd_pkg::ByteW-1:0] a,
                                      logic [brd_pkg::ByteW-1:0] b, logic pair,
                                      logic at_limit);
    word_t w;
    w.byte_a   = a;
    w.byte_b   = pair ? b : '0;
    w.pair     = pair;
    w.run_last = 1'b0;
    w.at_limit = at_limit;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : decode_and_compare
    longint unsigned eff_lim;
    longint unsigned room;
    longint unsigned k;
    int              first;
    word_t           w;
    logic [7:0]      exp_f [5];
    logic [7:0]      got_f [5];
    if (!rst_ni) begin
      limit_q     = brd_pkg::LimitRst;
      phase_q     = DecHeader;
      lit_left_q  = '0;
      rep_count_q = '0;
      out_cnt_q   = 0;
      decoded_q.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        limit_q = cfg_wdata_i;
      end

      if (in_valid_i && in_ready_i) begin
        eff_lim = limit_q;
        if (eff_lim > CountMax) begin
          eff_lim = CountMax;
        end
        first = decoded_q.size();
        if (out_cnt_q < eff_lim) begin
          case (phase_q)
            DecLiteral: begin
              out_cnt_q++;
              decoded_q.push_back(pack_word(data_byte_i, '0, 1'b0, out_cnt_q >= eff_lim));
              lit_left_q = lit_left_q - 1'b1;
              if (lit_left_q == '0) begin
                phase_q = DecHeader;
              end
            end
            DecValue: begin
              k    = rep_count_q;
              room = eff_lim - out_cnt_q;
              if (k > room) begin
                k = room;
              end
              while (k >= 2) begin
                out_cnt_q += 2;
                decoded_q.push_back(pack_word(data_byte_i, data_byte_i, 1'b1,
                                              out_cnt_q >= eff_lim));
                k -= 2;
              end
              if (k == 1) begin
                out_cnt_q++;
                decoded_q.push_back(pack_word(data_byte_i, '0, 1'b0, out_cnt_q >= eff_lim));
              end
              rep_count_q = '0;
              phase_q     = DecHeader;
            end
            default: begin
              // header byte: bit 7 picks literal run or repeat count
              if (data_byte_i[7]) begin
                lit_left_q = data_byte_i[brd_pkg::LenW-1:0];
                phase_q    = (lit_left_q != '0) ? DecLiteral : DecHeader;
              end else begin
                rep_count_q = data_byte_i[brd_pkg::LenW-1:0];
                phase_q     = DecValue;
              end
            end
          endcase
        end
        if (decoded_q.size() > first) begin
          w = decoded_q.pop_back();
          w.run_last = 1'b1;
          decoded_q.push_back(w);
        end
        if (last_byte_i) begin
          phase_q     = DecHeader;
          lit_left_q  = '0;
          rep_count_q = '0;
          out_cnt_q   = 0;
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          fails++;
          $display("%0t unexpected word: expected none, got a=%0h b=%0h pair=%0b last=%0b lim=%0b",
                   $time, out_byte_a_i, out_byte_b_i, pair_valid_i, run_last_i,
                   limit_reached_i);
        end else begin
          w = decoded_q.pop_front();
          exp_f = '{w.byte_a, w.byte_b, 8'(w.pair), 8'(w.run_last), 8'(w.at_limit)};
          got_f = '{out_byte_a_i, out_byte_b_i, 8'(pair_valid_i), 8'(run_last_i),
                    8'(limit_reached_i)};
          for (int f = 0; f < 5; f++) begin
            if (got_f[f] !== exp_f[f]) begin
              fails++;
              $display("%0t %s: expected %0h, got %0h", $time, field_name[f], exp_f[f],
                       got_f[f]);
            end
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= decoded_q.size();
    end
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 4;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [brd_pkg::LimitW-1:0] cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic [brd_pkg::ByteW-1:0]  data_byte;
  logic                       last_byte;
  logic                       out_valid;
  logic                       out_ready;
  logic [brd_pkg::ByteW-1:0]  out_byte_a;
  logic [brd_pkg::ByteW-1:0]  out_byte_b;
  logic                       pair_valid;
  logic                       run_last;
  logic                       limit_reached;

  int   fails;
  int   pending;
  int   bytes_sent;
  logic quiet;
  logic hold_req;

  byte_rle_decoder_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_a_o   (out_byte_a),
    .out_byte_b_o   (out_byte_b),
    .pair_valid_o   (pair_valid),
    .run_last_o     (run_last),
    .limit_reached_o(limit_reached)
  );

  brd_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_a_i   (out_byte_a),
    .out_byte_b_i   (out_byte_b),
    .pair_valid_i   (pair_valid),
    .run_last_i     (run_last),
    .limit_reached_i(limit_reached),
    .fail_count_o   (fails),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin : sink
    int stall_left;
    int held;
    stall_left = 0;
    held       = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && held < HoldCycles) begin
        out_ready <= 1'b0;
        held++;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called at a rising edge; returns at the edge where the byte is taken
  task automatic send(input logic [brd_pkg::ByteW-1:0] d, input logic l);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // stop offering and wait for every expected word, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limit(input logic [brd_pkg::LimitW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_image(input int runs);
    logic [brd_pkg::ByteW-1:0] img [$];
    int                        len;
    int                        cut;
    for (int r = 0; r < runs; r++) begin
      if ($urandom_range(0, 1) == 1) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 8);
        img.push_back(8'h80 | 8'(len));
        repeat (len) img.push_back(8'($urandom));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 20);
        img.push_back(8'(len));
        img.push_back(8'($urandom));
      end
    end
    case ($urandom_range(0, 11))
      0: begin
        // truncated mid-run
        cut = $urandom_range(1, img.size());
        while (img.size() > cut) void'(img.pop_back());
      end
      1: begin
        // plain noise
        img.delete();
        repeat ($urandom_range(1, 12)) img.push_back(8'($urandom));
      end
      default: ;
    endcase
    foreach (img[i]) begin
      send(img[i], i == img.size() - 1);
    end
  endtask

  task automatic random_phase(input int target);
    bytes_sent = 0;
    while (bytes_sent < target) begin
      send_image($urandom_range(1, 6));
      if (!quiet && $urandom_range(0, 7) == 0) begin
        drain();
      end
    end
  endtask

  initial begin : stimulus
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    data_byte  <= '0;
    last_byte  <= 1'b0;
    quiet      <= 1'b0;
    hold_req   <= 1'b0;
    bytes_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: empty literal, literal of three, zero repeat, longest repeat,
    // odd and even short repeats, truncated literal, truncated repeat
    send(8'h80, 1'b0);
    send(8'h83, 1'b0); send(8'h00, 1'b0); send(8'hFF, 1'b0); send(8'h5A, 1'b0);
    send(8'h00, 1'b0); send(8'h11, 1'b0);
    send(8'h7F, 1'b0); send(8'hFF, 1'b0);
    send(8'h01, 1'b0); send(8'hAB, 1'b0);
    send(8'h02, 1'b0); send(8'h00, 1'b0);
    send(8'h85, 1'b0); send(8'h3C, 1'b0); send(8'hC3, 1'b1);
    send(8'h05, 1'b1);
    drain();

    // smallest limit: repeat cut to one byte, then the rest of the image is ignored
    write_limit(16'd1);
    send(8'h04, 1'b0); send(8'h77, 1'b0); send(8'h82, 1'b0); send(8'h01, 1'b1);
    drain();
    // odd cut of a long repeat
    write_limit(16'd3);
    send(8'h7F, 1'b0); send(8'h00, 1'b1);
    drain();
    // limit lowered in the middle of an image
    write_limit(16'hFFFF);
    send(8'h84, 1'b0); send(8'hE1, 1'b0); send(8'h1E, 1'b0);
    drain();
    write_limit(16'd3);
    send(8'h99, 1'b0); send(8'h42, 1'b1);
    drain();

    write_limit(16'hFFFF);
    hold_req <= 1'b1;
    random_phase(70);
    hold_req <= 1'b0;
    drain();

    write_limit(16'($urandom_range(20, 300)));
    random_phase(45);
    drain();

    write_limit(16'($urandom_range(1, 65535)));
    random_phase(45);
    drain();

    write_limit(16'hFFFF);
    quiet <= 1'b1;
    random_phase(45);
    drain();

    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
